FILE: design/false_color_palette_mapper_macros.svh
// ----------------------------------------------------------------------------
// false colour palette mapper assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef FALSE_COLOR_PALETTE_MAPPER_MACROS_SVH
`define FALSE_COLOR_PALETTE_MAPPER_MACROS_SVH

// same-cycle implication
`define FCPM_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcpm same-cycle check failed");

// next-cycle implication
`define FCPM_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcpm next-cycle check failed");

`endif

FILE: design/fcpm_pkg.sv
// ----------------------------------------------------------------------------
// fcpm_pkg
// types and constants of the false colour palette mapper
// ----------------------------------------------------------------------------
package fcpm_pkg;

   localparam int CH_W       = 8;
   localparam int SEG_W      = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int SEL_W      = 3;

   // register index taken from csr_paddr[2]
   localparam logic REG_PALETTE_SELECT = 1'b0;

   typedef enum logic [SEL_W-1:0] {
      PAL_LINEAR  = 3'd0,
      PAL_TERRAIN = 3'd1,
      PAL_EARTH   = 3'd2,
      PAL_HSV     = 3'd3,
      PAL_RGB     = 3'd4
   } palette_type;

   localparam logic [SEG_W-1:0] SEG_0 = 3'd0;
   localparam logic [SEG_W-1:0] SEG_1 = 3'd1;
   localparam logic [SEG_W-1:0] SEG_2 = 3'd2;
   localparam logic [SEG_W-1:0] SEG_3 = 3'd3;
   localparam logic [SEG_W-1:0] SEG_4 = 3'd4;
   localparam logic [SEG_W-1:0] SEG_5 = 3'd5;

   // x/10 as (x*205)>>11, exact for x below 1029
   localparam int DIV10_MUL   = 205;
   localparam int DIV10_SHIFT = 11;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

endpackage

FILE: design/fcpm_segment.sv
// ----------------------------------------------------------------------------
// fcpm_segment
// saturates the position and splits it into sixth segment and offset
// ----------------------------------------------------------------------------
module fcpm_segment #(
   parameter int POS_FRAC_BITS = 12
) (
   input  logic [POS_FRAC_BITS:0]        position,
   output logic [POS_FRAC_BITS:0]        pos_sat,
   output logic [fcpm_pkg::SEG_W-1:0]    seg,
   output logic [POS_FRAC_BITS:0]        offset
);
   import fcpm_pkg::*;

   localparam int F  = POS_FRAC_BITS;
   localparam int UW = F + 1;
   localparam int QW = F + 3;
   localparam logic [UW-1:0] SCALE = UW'(1) << F;

   logic [QW-1:0]    q;
   logic [QW-1:0]    q_m1;
   logic [SEG_W-1:0] seg_raw;
   logic [QW-1:0]    base;

   always_comb begin
      pos_sat = (position > SCALE) ? SCALE : position;
      q       = (QW'(pos_sat) << 2) + (QW'(pos_sat) << 1);
      q_m1    = q - QW'(1);
      seg_raw = (q == '0) ? SEG_0 : q_m1[QW-1:F];
      seg     = (seg_raw > SEG_5) ? SEG_5 : seg_raw;
      base    = QW'(seg) << F;
      offset  = UW'(q - base);
   end

endmodule

FILE: design/fcpm_palette.sv
// ----------------------------------------------------------------------------
// fcpm_palette
// piecewise-linear channel formulas of the five palettes
// ----------------------------------------------------------------------------
module fcpm_palette #(
   parameter int POS_FRAC_BITS = 12
) (
   input  logic [fcpm_pkg::SEL_W-1:0] palette_sel,
   input  logic [POS_FRAC_BITS:0]     pos_sat,
   input  logic [fcpm_pkg::SEG_W-1:0] seg,
   input  logic [POS_FRAC_BITS:0]     offset,
   output fcpm_pkg::rgb_type          colour
);
   import fcpm_pkg::*;

   localparam int F  = POS_FRAC_BITS;
   localparam int UW = F + 1;
   localparam int WW = F + 11;
   localparam int DW = 16;

   // floor(k*u/S)
   function automatic logic [CH_W-1:0] mul_dn(input logic [7:0] k, input logic [UW-1:0] u);
      logic [WW-1:0] prod;
      prod = WW'(k) * WW'(u);
      return CH_W'(prod >> F);
   endfunction

   // ceil(k*u/S)
   function automatic logic [CH_W-1:0] mul_up(input logic [7:0] k, input logic [UW-1:0] u);
      logic [WW-1:0] prod;
      prod = WW'(k) * WW'(u) + ((WW'(1) << F) - WW'(1));
      return CH_W'(prod >> F);
   endfunction

   // floor((base*S + k*u) / 2^(F+sh))
   function automatic logic [CH_W-1:0] affine(input logic [9:0] base, input logic [7:0] k,
                                              input logic [UW-1:0] u, input logic [1:0] sh);
      logic [WW-1:0] acc;
      acc = (WW'(base) << F) + WW'(k) * WW'(u);
      return CH_W'(acc >> (F + int'(sh)));
   endfunction

   logic [CH_W-1:0] r;
   logic [CH_W-1:0] g;
   logic [CH_W-1:0] b;
   logic [CH_W-1:0] terr_b0_raw;
   logic [DW-1:0]   terr_b0_prod;
   logic            upper;

   always_comb begin
      r            = '0;
      g            = '0;
      b            = '0;
      upper        = (seg == SEG_5);
      terr_b0_raw  = mul_dn(8'd112, offset);
      terr_b0_prod = DW'(terr_b0_raw) * DW'(DIV10_MUL);
      case (palette_type'(palette_sel))
         PAL_LINEAR: begin
            r = 8'd20 + mul_dn(8'd235, pos_sat);
            g = r;
            b = r;
         end
         PAL_TERRAIN, PAL_EARTH: begin
            case (seg)
               SEG_0: begin
                  if (palette_type'(palette_sel) == PAL_TERRAIN) begin
                     r = mul_dn(8'd184, offset);
                     g = mul_dn(8'd134, offset);
                     b = CH_W'(terr_b0_prod >> DIV10_SHIFT);
                  end else begin
                     b = mul_dn(8'd255, offset);
                  end
               end
               SEG_1: begin
                  g = (palette_type'(palette_sel) == PAL_TERRAIN) ?
                      mul_dn(8'd150, offset) : mul_dn(8'd250, offset);
               end
               SEG_2: begin
                  g = (palette_type'(palette_sel) == PAL_TERRAIN) ? 8'd150 : 8'd250;
               end
               SEG_3: begin
                  if (palette_type'(palette_sel) == PAL_TERRAIN) begin
                     r = 8'd34 + mul_dn(8'd75, offset);
                     g = 8'd150;
                     b = affine(10'd68, 8'd153, offset, 2'd1);
                  end else begin
                     r = mul_dn(8'd250, offset);
                     g = 8'd250;
                  end
               end
               default: begin
                  // shared bright tail
                  r = affine(upper ? 10'd750 : 10'd500, 8'd250, offset, 2'd2);
                  g = r;
                  b = affine(upper ? 10'd765 : 10'd500, 8'd255, offset, 2'd2);
               end
            endcase
         end
         PAL_HSV: begin
            case (seg)
               SEG_0: begin
                  r = 8'd100;
                  b = mul_dn(8'd200, offset);
               end
               SEG_1: begin
                  r = 8'd100 - mul_up(8'd100, offset);
                  b = 8'd200;
               end
               SEG_2: begin
                  g = mul_dn(8'd255, offset);
                  b = 8'd200;
               end
               SEG_3: begin
                  g = 8'd255;
                  b = 8'd200 - mul_up(8'd200, offset);
               end
               SEG_4: begin
                  r = mul_dn(8'd100, offset);
                  g = 8'd255;
               end
               default: begin
                  r = 8'd100;
                  g = 8'd255 - mul_up(8'd255, offset);
               end
            endcase
         end
         default: begin
            // rgb palette, also taken by the unused codes
            case (seg)
               SEG_0: begin
                  b = mul_dn(8'd255, offset);
               end
               SEG_1: begin
                  g = mul_dn(8'd250, offset);
                  b = 8'd255;
               end
               SEG_2: begin
                  g = 8'd250;
                  b = 8'd255 - mul_up(8'd255, offset);
               end
               SEG_3: begin
                  r = mul_dn(8'd250, offset);
                  g = 8'd250;
               end
               SEG_4: begin
                  r = 8'd250;
                  g = 8'd250 - mul_up(8'd250, offset);
               end
               default: begin
                  r = 8'd250 - mul_up(8'd250, offset);
               end
            endcase
         end
      endcase
      colour.red   = r;
      colour.green = g;
      colour.blue  = b;
   end

endmodule

FILE: design/false_color_palette_mapper.sv
// ----------------------------------------------------------------------------
// false_color_palette_mapper
// maps a normalised position to an rgb colour through a selectable palette
// ----------------------------------------------------------------------------
// rsp_valid rises once the colour of an accepted req beat sits in the colour register
// throughput: 1 beat per cycle while rsp_stall is low, set by the two-register pipeline
// (position register, then colour register) that advances whenever it can
// reset: synchronous, clears both pipeline stages and sets the linear palette
module false_color_palette_mapper #(
   parameter int POS_FRAC_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   // request channel
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [POS_FRAC_BITS:0]           req_position,
   // response channel
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fcpm_pkg::CH_W-1:0]        rsp_red,
   output logic [fcpm_pkg::CH_W-1:0]        rsp_green,
   output logic [fcpm_pkg::CH_W-1:0]        rsp_blue,
   // register port
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [fcpm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [fcpm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [fcpm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import fcpm_pkg::*;

   localparam int UW = POS_FRAC_BITS + 1;

   // palette select register
   logic [SEL_W-1:0] palette_sel_ff;
   logic [SEL_W-1:0] palette_sel_in;
   logic             csr_wr;
   logic             csr_hit;

   // stage 1: registered position
   logic             s1_valid_ff;
   logic             s1_valid_in;
   logic [UW-1:0]    s1_pos_ff;

   // stage 2: finished colour
   logic             s2_valid_ff;
   logic             s2_valid_in;
   rgb_type          s2_rgb_ff;

   logic             s1_en;
   logic             s2_en;
   logic [UW-1:0]    seg_pos;
   logic [SEG_W-1:0] seg_idx;
   logic [UW-1:0]    seg_off;
   rgb_type          colour;

   // apb access: always ready, single register at index 0
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == REG_PALETTE_SELECT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      palette_sel_in = palette_sel_ff;
      if (csr_wr && csr_hit) begin
         palette_sel_in = csr_pwdata[SEL_W-1:0];
      end
      csr_prdata = csr_hit ? CSR_DATA_W'(palette_sel_ff) : '0;
   end

   // pipeline moves a stage on when the one after it is empty or draining
   assign s2_en     = !s2_valid_ff || !rsp_stall;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;

   assign s1_valid_in = s1_en ? req_valid : s1_valid_ff;
   assign s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;

   // segment split and palette formulas sit between the two registers
   fcpm_segment #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_segment (
      .position (s1_pos_ff),
      .pos_sat  (seg_pos),
      .seg      (seg_idx),
      .offset   (seg_off)
   );

   fcpm_palette #(
      .POS_FRAC_BITS (POS_FRAC_BITS)
   ) u_palette (
      .palette_sel (palette_sel_ff),
      .pos_sat     (seg_pos),
      .seg         (seg_idx),
      .offset      (seg_off),
      .colour      (colour)
   );

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         palette_sel_ff <= SEL_W'(PAL_LINEAR);
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
      end else begin
         palette_sel_ff <= palette_sel_in;
         s1_valid_ff    <= s1_valid_in;
         s2_valid_ff    <= s2_valid_in;
      end
   end

   // payload, no reset needed
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_pos_ff <= req_position;
      end
      if (s2_en) begin
         s2_rgb_ff <= colour;
      end
   end

   assign rsp_valid = s2_valid_ff;
   assign rsp_red   = s2_rgb_ff.red;
   assign rsp_green = s2_rgb_ff.green;
   assign rsp_blue  = s2_rgb_ff.blue;

endmodule

FILE: design/fcpm_checker.sv
// ----------------------------------------------------------------------------
// fcpm_checker
// port-level checks of the false colour palette mapper
// ----------------------------------------------------------------------------
`include "false_color_palette_mapper_macros.svh"

module fcpm_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_stall,
   input logic                             rsp_valid,
   input logic                             rsp_stall,
   input logic [fcpm_pkg::CH_W-1:0]        rsp_red,
   input logic [fcpm_pkg::CH_W-1:0]        rsp_green,
   input logic [fcpm_pkg::CH_W-1:0]        rsp_blue,
   input logic                             csr_psel,
   input logic                             csr_penable,
   input logic                             csr_pwrite,
   input logic [fcpm_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input logic [fcpm_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input logic [fcpm_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input logic                             csr_pready
);
   import fcpm_pkg::*;

   logic pal_wr;
   assign pal_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[2] == REG_PALETTE_SELECT);

   // a stalled beat stays put
   `FCPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_red) && $stable(rsp_green) && $stable(rsp_blue))
   // empty output stage never back-pressures the request side
   `FCPM_ASSERT_SAME(a_no_idle_stall, clock, reset, !rsp_valid, !req_stall)
   // reset empties the pipeline
   `FCPM_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_valid)
   // palette register reads back what was written
   `FCPM_ASSERT_NEXT(a_readback, clock, reset, pal_wr, (csr_paddr[2] != REG_PALETTE_SELECT) || (csr_prdata[SEL_W-1:0] == $past(csr_pwdata[SEL_W-1:0])))

endmodule

bind false_color_palette_mapper fcpm_checker u_fcpm_checker (.*);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// false colour palette mapper testbench
// drives position beats through all palette codes and checks every colour
// beat against a predictor kept in step with the palette register, with
// random gaps on the request side and random stalls on the response side
// ----------------------------------------------------------------------------
module testbench;
   import fcpm_pkg::*;

   localparam int FRAC      = 12;
   localparam int SPAN      = 1 << FRAC;
   localparam int POS_W     = FRAC + 1;
   localparam int LATENCY   = 2;
   localparam int CYCLE_CAP = 200000;
   localparam int PHASES    = 11;
   localparam int PHASE_LEN = 45;
   localparam int PRINT_CAP = 40;

   // palette register, byte address 0
   localparam logic [CSR_ADDR_W-1:0] PALETTE_ADDR = {REG_PALETTE_SELECT, 2'b00};

   // codes outside the named palettes, which fall back to rgb
   localparam logic [SEL_W-1:0] UNKNOWN_CODE_LOW  = 3'd5;
   localparam logic [SEL_W-1:0] UNKNOWN_CODE_HIGH = 3'd7;

   typedef struct packed {
      logic [SEL_W-1:0] code;
      logic [POS_W-1:0] position;
      logic             known;
      rgb_type          colour;
   } directed_row_type;

   typedef struct {
      rgb_type          colour;
      logic [SEL_W-1:0] code;
      logic [POS_W-1:0] position;
   } colour_entry_type;

   // directed beats: known colours typed in, the rest left to the predictor
   localparam directed_row_type DIRECTED [25] = '{
      // reset palette is linear: grey 20 up to white
      '{PAL_LINEAR,  13'd0,    1'b1, {8'd20,  8'd20,  8'd20}},
      '{PAL_LINEAR,  13'd4096, 1'b1, {8'd255, 8'd255, 8'd255}},
      // position above one saturates
      '{PAL_LINEAR,  13'd8191, 1'b1, {8'd255, 8'd255, 8'd255}},
      '{PAL_LINEAR,  13'd2048, 1'b1, {8'd137, 8'd137, 8'd137}},
      '{PAL_TERRAIN, 13'd0,    1'b1, {8'd0,   8'd0,   8'd0}},
      '{PAL_TERRAIN, 13'd4096, 1'b1, {8'd250, 8'd250, 8'd255}},
      // exact boundary belongs to the lower segment
      '{PAL_TERRAIN, 13'd2048, 1'b1, {8'd0,   8'd150, 8'd0}},
      '{PAL_TERRAIN, 13'd682,  1'b0, '0},
      '{PAL_TERRAIN, 13'd3000, 1'b0, '0},
      '{PAL_EARTH,   13'd0,    1'b1, {8'd0,   8'd0,   8'd0}},
      '{PAL_EARTH,   13'd2048, 1'b1, {8'd0,   8'd250, 8'd0}},
      '{PAL_EARTH,   13'd2731, 1'b0, '0},
      '{PAL_EARTH,   13'd8191, 1'b1, {8'd250, 8'd250, 8'd255}},
      '{PAL_HSV,     13'd0,    1'b1, {8'd100, 8'd0,   8'd0}},
      '{PAL_HSV,     13'd2048, 1'b1, {8'd0,   8'd255, 8'd200}},
      '{PAL_HSV,     13'd1000, 1'b0, '0},
      '{PAL_HSV,     13'd3500, 1'b0, '0},
      '{PAL_HSV,     13'd4096, 1'b1, {8'd100, 8'd0,   8'd0}},
      '{PAL_RGB,     13'd0,    1'b1, {8'd0,   8'd0,   8'd0}},
      '{PAL_RGB,     13'd2048, 1'b1, {8'd0,   8'd250, 8'd0}},
      '{PAL_RGB,     13'd1500, 1'b0, '0},
      '{PAL_RGB,     13'd2500, 1'b0, '0},
      '{PAL_RGB,     13'd4096, 1'b1, {8'd0,   8'd0,   8'd0}},
      // unknown codes behave as rgb
      '{UNKNOWN_CODE_HIGH, 13'd4096, 1'b1, {8'd0, 8'd0,   8'd0}},
      '{UNKNOWN_CODE_LOW,  13'd2048, 1'b1, {8'd0, 8'd250, 8'd0}}
   };

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic [POS_W-1:0]      req_position;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [CH_W-1:0]       rsp_red;
   logic [CH_W-1:0]       rsp_green;
   logic [CH_W-1:0]       rsp_blue;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   colour_entry_type      pending_colours[$];
   logic [SEL_W-1:0]      palette_now;
   bit                    idling_on;
   int                    mismatch_count;
   int                    beats_sent;
   int                    beats_checked;
   int                    palette_writes;
   int                    cycle_count;
   int                    stall_left;

   false_color_palette_mapper #(
      .POS_FRAC_BITS(FRAC)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_position(req_position),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_red     (rsp_red),
      .rsp_green   (rsp_green),
      .rsp_blue    (rsp_blue),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // floor and ceiling of k*u/SPAN
   function automatic longint unsigned ramp_down(input longint unsigned k,
                                                 input longint unsigned u);
      return (k * u) >> FRAC;
   endfunction

   function automatic longint unsigned ramp_up(input longint unsigned k,
                                               input longint unsigned u);
      return (k * u + SPAN - 1) >> FRAC;
   endfunction

   // two top segments, common to terrain and earth: fade to near white
   function automatic rgb_type bright_tail(input logic [SEG_W-1:0] seg,
                                           input longint unsigned u);
      longint unsigned d;
      longint unsigned r;
      longint unsigned b;
      d = 4 * SPAN;
      if (seg == SEG_4) begin
         r = (500 * SPAN + 250 * u) / d;
         b = (500 * SPAN + 255 * u) / d;
      end else begin
         r = (750 * SPAN + 250 * u) / d;
         b = (765 * SPAN + 255 * u) / d;
      end
      return {r[7:0], r[7:0], b[7:0]};
   endfunction

   // colour the block should produce for a position under a palette code
   function automatic rgb_type palette_colour(input logic [SEL_W-1:0] code,
                                              input logic [POS_W-1:0] position);
      longint unsigned p;
      longint unsigned q;
      longint unsigned u;
      longint unsigned r;
      longint unsigned g;
      longint unsigned b;
      logic [SEG_W-1:0] seg;
      p = (position > SPAN) ? SPAN : position;
      q = 6 * p;
      // boundary positions fall into the segment below
      seg = (q == 0) ? SEG_0 : SEG_W'((q - 1) >> FRAC);
      u = q - seg * SPAN;
      r = 0;
      g = 0;
      b = 0;
      case (code)
         PAL_LINEAR: begin
            r = 20 + ramp_down(235, p);
            g = r;
            b = r;
         end
         PAL_TERRAIN, PAL_EARTH: begin
            if (seg >= SEG_4) return bright_tail(seg, u);
            if (code == PAL_TERRAIN) begin
               case (seg)
                  SEG_0: begin
                     r = ramp_down(184, u);
                     g = ramp_down(134, u);
                     b = (112 * u) / (10 * SPAN);
                  end
                  SEG_1: g = ramp_down(150, u);
                  SEG_2: g = 150;
                  default: begin
                     r = 34 + ramp_down(75, u);
                     g = 150;
                     b = (68 * SPAN + 153 * u) / (2 * SPAN);
                  end
               endcase
            end else begin
               case (seg)
                  SEG_0: b = ramp_down(255, u);
                  SEG_1: g = ramp_down(250, u);
                  SEG_2: g = 250;
                  default: begin
                     r = ramp_down(250, u);
                     g = 250;
                  end
               endcase
            end
         end
         PAL_HSV: begin
            case (seg)
               SEG_0: begin r = 100; b = ramp_down(200, u); end
               SEG_1: begin r = 100 - ramp_up(100, u); b = 200; end
               SEG_2: begin g = ramp_down(255, u); b = 200; end
               SEG_3: begin g = 255; b = 200 - ramp_up(200, u); end
               SEG_4: begin r = ramp_down(100, u); g = 255; end
               default: begin r = 100; g = 255 - ramp_up(255, u); end
            endcase
         end
         // rgb, and every code past it
         default: begin
            case (seg)
               SEG_0: b = ramp_down(255, u);
               SEG_1: begin g = ramp_down(250, u); b = 255; end
               SEG_2: begin g = 250; b = 255 - ramp_up(255, u); end
               SEG_3: begin r = ramp_down(250, u); g = 250; end
               SEG_4: begin r = 250; g = 250 - ramp_up(250, u); end
               default: r = 250 - ramp_up(250, u);
            endcase
         end
      endcase
      return {r[7:0], g[7:0], b[7:0]};
   endfunction

   // mostly in range, some on segment boundaries, some past one
   function automatic logic [POS_W-1:0] random_position();
      int pick;
      int k;
      pick = $urandom_range(0, 99);
      k = $urandom_range(0, 6);
      if (pick < 10) return POS_W'($urandom_range(SPAN + 1, (1 << POS_W) - 1));
      if (pick < 25) return POS_W'((k * SPAN) / 6 + $urandom_range(0, 2));
      return POS_W'($urandom_range(0, SPAN));
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want,
                                  input logic [SEL_W-1:0] code,
                                  input logic [POS_W-1:0] position);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("mismatch %s: got %0d want %0d (palette %0d, position %0d)",
                  what, got, want, code, position);
   endtask

   // setup then access, once for the write and once for the read back
   task automatic set_palette(input logic [SEL_W-1:0] code);
      logic [CSR_DATA_W-1:0] readback;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= PALETTE_ADDR;
      // upper bits are don't care for a three bit register
      csr_pwdata  <= {CSR_DATA_W'($urandom) & ~CSR_DATA_W'(7)} | CSR_DATA_W'(code);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      palette_now = code;
      palette_writes++;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      readback = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback != CSR_DATA_W'(code))
         report_mismatch("palette readback", readback, code, code, '0);
   endtask

   // drop valid, let every colour beat come back, then a few spare cycles
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_colours.size() != 0) @(posedge clock);
      repeat (LATENCY + 1) @(posedge clock);
   endtask

   // one position beat; a known colour replaces the prediction
   task automatic send_position(input logic [POS_W-1:0] position, input logic known,
                                input rgb_type colour);
      colour_entry_type entry;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_position <= position;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      entry.code     = palette_now;
      entry.position = position;
      entry.colour   = known ? colour : palette_colour(palette_now, position);
      pending_colours.insert(pending_colours.size(), entry);
      beats_sent++;
   endtask

   // response side stalls in bursts
   always @(posedge clock) begin
      if (reset || !idling_on) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // colour beat checker, oldest expectation first
   always @(posedge clock) begin
      colour_entry_type entry;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_colours.size() == 0) begin
            report_mismatch("unexpected colour beat, red", rsp_red, 0, palette_now, '0);
         end else begin
            entry = pending_colours.pop_front();
            beats_checked++;
            if (rsp_red !== entry.colour.red)
               report_mismatch("red", rsp_red, entry.colour.red, entry.code, entry.position);
            if (rsp_green !== entry.colour.green)
               report_mismatch("green", rsp_green, entry.colour.green, entry.code,
                               entry.position);
            if (rsp_blue !== entry.colour.blue)
               report_mismatch("blue", rsp_blue, entry.colour.blue, entry.code,
                               entry.position);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout after %0d cycles, %0d colour beats outstanding", cycle_count,
                  pending_colours.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      logic [SEL_W-1:0] code;
      mismatch_count = 0;
      beats_sent     = 0;
      beats_checked  = 0;
      palette_writes = 0;
      idling_on      = 1'b1;
      palette_now    = PAL_LINEAR;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_position <= '0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, starting on the reset palette
      foreach (DIRECTED[i]) begin
         if (DIRECTED[i].code != palette_now) begin
            settle();
            set_palette(DIRECTED[i].code);
         end
         send_position(DIRECTED[i].position, DIRECTED[i].known, DIRECTED[i].colour);
      end

      // random part: every code once in order, then random codes;
      // the last phase runs flat out on both sides
      for (int phase = 0; phase < PHASES; phase++) begin
         code = (phase < 8) ? SEL_W'(phase) : SEL_W'($urandom_range(0, 7));
         settle();
         set_palette(code);
         if (phase == PHASES - 1) idling_on = 1'b0;
         repeat (PHASE_LEN) send_position(random_position(), 1'b0, '0);
      end

      settle();
      repeat (LATENCY * 4) @(posedge clock);
      $display("%0d position beats sent, %0d colour beats checked", beats_sent, beats_checked);
      $display("%0d palette writes, covering codes 0 to 7 and saturated positions",
               palette_writes);
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("%0d mismatches", mismatch_count);
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
